@@ sv/mandelbrot_escape_time_pixel_assert.svh @@
// Assertion macros for the RTL of the escape-time pixel block.
// Each macro takes a label, an antecedent and a consequent.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mandelbrot escape time: check failed");
// Next-cycle implication.
`define MET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mandelbrot escape time: check failed");
`else
`define MET_ASSERT_IMP(lbl, ante, cons)
`define MET_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/met_pkg.sv @@
package met_pkg;

  // Fixed-point format of all coordinates: signed Q4.28 in 32 bits.
  localparam int FRACTION_BITS = 28;
  localparam int IMAGE_WIDTH   = 1024;
  localparam int IMAGE_HEIGHT  = 1024;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 11;
  localparam int PIXEL_W = 8;

  localparam logic [PIXEL_W-1:0] IN_SET_CODE = 8'd255;

  localparam logic [63:0] ONE_Q     = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] FRAC_MASK = ONE_Q - 64'd1;

  // Reset values, rounded to nearest in the Q format.
  localparam logic [31:0] ORIGIN_REAL_RST = 32'(64'd0 - (64'd22 * ONE_Q + 64'd5) / 64'd10);
  localparam logic [31:0] ORIGIN_IMAG_RST = 32'(64'd0 - (64'd15 * ONE_Q + 64'd5) / 64'd10);
  localparam logic [63:0] DEN_REAL        = 64'd10 * 64'(IMAGE_WIDTH);
  localparam logic [63:0] DEN_IMAG        = 64'd10 * 64'(IMAGE_HEIGHT);
  localparam logic [30:0] STEP_REAL_RST   = 31'((64'd29 * ONE_Q + DEN_REAL / 64'd2) / DEN_REAL);
  localparam logic [30:0] STEP_IMAG_RST   = 31'((64'd29 * ONE_Q + DEN_IMAG / 64'd2) / DEN_IMAG);
  localparam logic [10:0] LIMIT_RST       = 11'd50;
  localparam logic [31:0] BOUND_RST       = 32'(64'd4 * ONE_Q);

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ORIGIN_REAL     = 3'd0,
    REG_ORIGIN_IMAG     = 3'd1,
    REG_STEP_REAL       = 3'd2,
    REG_STEP_IMAG       = 3'd3,
    REG_ITERATION_LIMIT = 3'd4,
    REG_ESCAPE_BOUND    = 3'd5
  } met_reg_t;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic signed [31:0]  origin_real;
    logic signed [31:0]  origin_imag;
    logic [30:0]         step_real;
    logic [30:0]         step_imag;
    logic [COUNT_W-1:0]  iteration_limit;
    logic [31:0]         escape_bound;
  } met_cfg_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/met_pixel_if.sv @@
interface met_pixel_if import met_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

@@ sv/met_result_if.sv @@
interface met_result_if import met_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic               in_set;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output iteration_count, output in_set,
                  output pixel_value, input ready);
  modport sink   (input valid, input iteration_count, input in_set,
                  input pixel_value, output ready);
endinterface

@@ sv/met_cfg_regs.sv @@
module met_cfg_regs import met_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output met_cfg_t          cfg
);

  logic     wr_en;
  met_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = met_reg_t'(paddr[ADDR_W-1:2]);

  // Register writes in the access phase; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real     <= ORIGIN_REAL_RST;
      cfg.origin_imag     <= ORIGIN_IMAG_RST;
      cfg.step_real       <= STEP_REAL_RST;
      cfg.step_imag       <= STEP_IMAG_RST;
      cfg.iteration_limit <= LIMIT_RST;
      cfg.escape_bound    <= BOUND_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ORIGIN_REAL:     cfg.origin_real     <= pwdata;
        REG_ORIGIN_IMAG:     cfg.origin_imag     <= pwdata;
        REG_STEP_REAL:       cfg.step_real       <= pwdata[30:0];
        REG_STEP_IMAG:       cfg.step_imag       <= pwdata[30:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= pwdata[COUNT_W-1:0];
        REG_ESCAPE_BOUND:    cfg.escape_bound    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_REAL:     prdata = cfg.origin_real;
      REG_ORIGIN_IMAG:     prdata = cfg.origin_imag;
      REG_STEP_REAL:       prdata = {1'b0, cfg.step_real};
      REG_STEP_IMAG:       prdata = {1'b0, cfg.step_imag};
      REG_ITERATION_LIMIT: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg.iteration_limit};
      REG_ESCAPE_BOUND:    prdata = cfg.escape_bound;
      default:             prdata = '0;
    endcase
  end

endmodule

@@ sv/met_mult.sv @@
module met_mult (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ sv/mandelbrot_escape_time_pixel.sv @@
// Mandelbrot escape-time pixel evaluator.
// A request on the pixel channel carries a column and a row. The block maps
// them to c = origin + step * coordinate, then iterates z = z*z + c from z = c
// until |z|^2 exceeds the escape bound or the iteration limit is reached.
// The result channel returns the iteration count, the in-set flag and an
// 8-bit pixel code (255 inside the set, else the count modulo 256).
// One signed 32x32 multiplier is shared by all products under a small
// sequencer: point mapping runs through MAP_R, MAP_I and MAP_C, and each
// iteration through SQX, SQY, MXY and CHK (x*x, y*y, x*y, then the escape
// test and update). The pixel channel is ready only while no pixel is in
// work, so the next pixel can be accepted from the cycle in which the
// result appears. A finished result sits in the output register; if the
// receiver stalls, the next pixel is still accepted and computed, and its
// result waits until the output register is free. Configuration goes through
// the APB-style port; the user must change it only while the block is idle,
// as the block does not enforce this. Reset is synchronous, puts the
// configuration registers to their defaults, returns the sequencer to idle
// and empties both channels.
`include "mandelbrot_escape_time_pixel_assert.svh"
module mandelbrot_escape_time_pixel import met_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  met_pixel_if.sink         pixel,
  met_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_R,
    S_MAP_I,
    S_MAP_C,
    S_SQX,
    S_SQY,
    S_MXY,
    S_CHK,
    S_DRAIN
  } state_t;

  met_cfg_t cfg;

  state_t              state;
  logic [COORD_W-1:0]  column_q;
  logic [COORD_W-1:0]  row_q;
  logic signed [31:0]  cr;
  logic signed [31:0]  ci;
  logic signed [31:0]  x;
  logic signed [31:0]  y;
  logic signed [63:0]  xx;
  logic signed [63:0]  diff;
  logic [63:0]         mag;
  logic [COUNT_W-1:0]  count;
  logic                in_set_q;

  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  prod;
  logic [63:0]         whole;
  logic [63:0]         bound_w;
  logic                in_bound;
  logic signed [31:0]  x_next;
  logic signed [31:0]  y_next;
  logic signed [31:0]  map_val;
  logic signed [31:0]  map_origin;
  logic                load_result;

  met_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  met_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign pixel.ready = (state == S_IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      S_MAP_R: begin
        mul_a = $signed({1'b0, cfg.step_real});
        mul_b = $signed({{(32-COORD_W){1'b0}}, column_q});
      end
      S_MAP_I: begin
        mul_a = $signed({1'b0, cfg.step_imag});
        mul_b = $signed({{(32-COORD_W){1'b0}}, row_q});
      end
      S_SQX: begin
        mul_a = x;
        mul_b = x;
      end
      S_SQY: begin
        mul_a = y;
        mul_b = y;
      end
      default: begin
        mul_a = x;
        mul_b = y;
      end
    endcase
  end

  // Point mapping: the product just out of the multiplier plus the origin.
  assign map_origin = (state == S_MAP_I) ? cfg.origin_real : cfg.origin_imag;
  assign map_val    = sat32(prod + 64'(map_origin));

  // Escape test on the registered magnitude: continue while mag <= bound.
  assign whole    = mag >> FRACTION_BITS;
  assign bound_w  = {32'd0, cfg.escape_bound};
  assign in_bound = (whole < bound_w) || ((whole == bound_w) && ((mag & FRAC_MASK) == 64'd0));

  // Update of z; the product out of the multiplier is x*y in the check cycle.
  assign x_next = sat32((diff >>> FRACTION_BITS) + 64'(cr));
  assign y_next = sat32((prod >>> (FRACTION_BITS - 1)) + 64'(ci));

  // The output register takes a new result when it is empty or being drained.
  assign load_result = (state == S_DRAIN) && (!result.valid || result.ready);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (load_result) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            column_q <= pixel.column;
            row_q    <= pixel.row;
            state    <= S_MAP_R;
          end
        end
        S_MAP_R: begin
          state <= S_MAP_I;
        end
        S_MAP_I: begin
          cr    <= map_val;
          state <= S_MAP_C;
        end
        S_MAP_C: begin
          ci    <= map_val;
          y     <= map_val;
          x     <= cr;
          count <= '0;
          state <= S_SQX;
        end
        S_SQX: begin
          if (count >= cfg.iteration_limit) begin
            in_set_q <= 1'b1;
            state    <= S_DRAIN;
          end else begin
            state <= S_SQY;
          end
        end
        S_SQY: begin
          xx    <= prod;
          state <= S_MXY;
        end
        S_MXY: begin
          mag   <= $unsigned(xx) + $unsigned(prod);
          diff  <= xx - prod;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!in_bound) begin
            in_set_q <= 1'b0;
            state    <= S_DRAIN;
          end else begin
            x     <= x_next;
            y     <= y_next;
            count <= count + 1'b1;
            state <= S_SQX;
          end
        end
        S_DRAIN: begin
          if (load_result) begin
            result.iteration_count <= count;
            result.in_set          <= in_set_q;
            result.pixel_value     <= in_set_q ? IN_SET_CODE : count[PIXEL_W-1:0];
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted pixel always starts with the real-axis mapping.
  `MET_ASSERT_NXT(a_start_map, pixel.valid && pixel.ready, state == S_MAP_R)
  // The check cycle is reached only below the iteration limit.
  `MET_ASSERT_IMP(a_count_below_limit, state == S_CHK, count < cfg.iteration_limit)
  // A result inside the set carries the in-set pixel code.
  `MET_ASSERT_IMP(a_in_set_code, result.valid && result.in_set,
                  result.pixel_value == IN_SET_CODE)
  // A result is loaded only when the output register is free or drains.
  `MET_ASSERT_NXT(a_drain_load, state == S_DRAIN && (!result.valid || result.ready),
                  result.valid && state == S_IDLE)

endmodule
